FILE: design/hssc_pkg.sv
// ----------------------------------------------------------------------------
// hssc_pkg: shared types and constants of the Hall six-step commutator
// Register indexes, widths, speed constants and controller/datapath structs.
// ----------------------------------------------------------------------------
package hssc_pkg;

  // PWM duty resolution; duties are taken in their low DUTY_WIDTH bits
  localparam int DUTY_WIDTH = 16;
  localparam logic [15:0] DUTY_MASK = 16'((32'd1 << DUTY_WIDTH) - 32'd1);

  // Speed numerator, 24-bit quotient, one quotient bit per divider step
  localparam logic [23:0] SPEED_NUMERATOR = 24'd10000000;
  localparam int          DIV_STEPS       = 24;

  // Configuration register indexes
  localparam logic [2:0] REG_REVERSE_DIRECTION = 3'd0;
  localparam logic [2:0] REG_DUTY_LOW          = 3'd1;
  localparam logic [2:0] REG_DUTY_HIGH         = 3'd2;
  localparam logic [2:0] REG_HALL_TABLE        = 3'd3;
  localparam logic [2:0] REG_PATTERN_TABLE     = 3'd4;

  localparam logic [31:0] HALL_TABLE_RESET = 32'hFFFF_FFFF;
  localparam logic [3:0]  LAST_POSITION    = 4'd5;

  // Commands from the controller
  typedef struct packed {
    logic accept;     // latch the input item and update edge timing
    logic div_start;  // load the speed divider
    logic div_step;   // one restoring-division step
    logic load_out;   // write the output register
  } ctrl_cmd_t;

  // Status from the datapath
  typedef struct packed {
    logic pos_valid;  // latched Hall state maps to a valid position
    logic step_zero;  // latched step is step 0
    logic out_free;   // output register can take a new item
  } dp_status_t;

endpackage

FILE: design/hssc_in_if.sv
// ----------------------------------------------------------------------------
// hssc_in_if: Hall edge input channel
// Valid/ready channel carrying the Hall state and the edge timestamp.
// ----------------------------------------------------------------------------
interface hssc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  hall_state;
  logic [31:0] edge_time_us;

  modport source (output valid, hall_state, edge_time_us, input ready);
  modport sink   (input valid, hall_state, edge_time_us, output ready);
endinterface

FILE: design/hssc_out_if.sv
// ----------------------------------------------------------------------------
// hssc_out_if: commutation result channel
// Valid/ready channel carrying step, six phase levels, interval and speed.
// ----------------------------------------------------------------------------
interface hssc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  commutation_step;
  logic [15:0] phase_a_low_level;
  logic [15:0] phase_a_high_level;
  logic [15:0] phase_b_low_level;
  logic [15:0] phase_b_high_level;
  logic [15:0] phase_c_low_level;
  logic [15:0] phase_c_high_level;
  logic [31:0] edge_interval_us;
  logic [23:0] speed_value;

  modport source (output valid, commutation_step, phase_a_low_level, phase_a_high_level,
                  phase_b_low_level, phase_b_high_level, phase_c_low_level,
                  phase_c_high_level, edge_interval_us, speed_value, input ready);
  modport sink   (input valid, commutation_step, phase_a_low_level, phase_a_high_level,
                  phase_b_low_level, phase_b_high_level, phase_c_low_level,
                  phase_c_high_level, edge_interval_us, speed_value, output ready);
endinterface

FILE: design/hssc_ctrl.sv
// ----------------------------------------------------------------------------
// hssc_ctrl: commutator sequencer
// Takes one item at a time, runs the speed divider on step 0 and hands the
// result of a valid item to the output register when it is free.
// ----------------------------------------------------------------------------
module hssc_ctrl
  import hssc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_FINISH
  } state_t;

  state_t     state;
  logic [4:0] div_count;

  // state and divider step count
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_CALC;
        end
        S_CALC: begin
          div_count <= '0;
          if (!status.pos_valid)     state <= S_IDLE;
          else if (status.step_zero) state <= S_DIV;
          else                       state <= S_FINISH;
        end
        S_DIV: begin
          div_count <= div_count + 5'd1;
          if (div_count == 5'(DIV_STEPS - 1)) state <= S_FINISH;
        end
        S_FINISH: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // commands decoded from state
  always_comb begin
    in_ready      = (state == S_IDLE);
    cmd.accept    = (state == S_IDLE) && in_valid;
    cmd.div_start = (state == S_CALC) && status.pos_valid && status.step_zero;
    cmd.div_step  = (state == S_DIV);
    cmd.load_out  = (state == S_FINISH) && status.out_free;
  end

endmodule

FILE: design/hssc_dp.sv
// ----------------------------------------------------------------------------
// hssc_dp: commutator datapath
// Configuration registers, position lookup, edge timing, serial speed
// divider and the output register.
// ----------------------------------------------------------------------------
module hssc_dp
  import hssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [35:0] cfg_data,
  // item in
  input  logic [2:0]  hall_state,
  input  logic [31:0] edge_time_us,
  // control
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  // item out
  input  logic        out_ready,
  output logic        out_valid,
  output logic [2:0]  commutation_step,
  output logic [15:0] phase_a_low_level,
  output logic [15:0] phase_a_high_level,
  output logic [15:0] phase_b_low_level,
  output logic [15:0] phase_b_high_level,
  output logic [15:0] phase_c_low_level,
  output logic [15:0] phase_c_high_level,
  output logic [31:0] edge_interval_us,
  output logic [23:0] speed_value
);

  // configuration registers
  logic        reverse_direction;
  logic [15:0] duty_low;
  logic [15:0] duty_high;
  logic [31:0] hall_position_table;
  logic [35:0] drive_pattern_table;

  // timing state
  logic [31:0] previous_edge_time;
  logic [31:0] revolution_start_time;
  logic [23:0] held_speed;

  // working registers of the current item
  logic        pos_valid;
  logic [2:0]  step;
  logic [31:0] interval;
  logic [31:0] period;
  logic        period_zero;

  // divider
  logic [31:0] div_rem;
  logic [23:0] div_quot;
  logic [32:0] div_trial;
  logic        div_bit;

  // lookup of the incoming item
  logic [3:0]  pos_in;
  logic [2:0]  step_in;
  logic [31:0] period_in;

  logic [5:0]  pattern;
  logic [15:0] level_low;
  logic [15:0] level_high;
  logic [23:0] speed_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_direction   <= 1'b0;
      duty_low            <= '0;
      duty_high           <= '0;
      hall_position_table <= HALL_TABLE_RESET;
      drive_pattern_table <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REVERSE_DIRECTION: reverse_direction   <= cfg_data[0];
        REG_DUTY_LOW:          duty_low            <= cfg_data[15:0];
        REG_DUTY_HIGH:         duty_high           <= cfg_data[15:0];
        REG_HALL_TABLE:        hall_position_table <= cfg_data[31:0];
        REG_PATTERN_TABLE:     drive_pattern_table <= cfg_data;
        default: ;
      endcase
    end
  end

  // position lookup and step wrap
  always_comb begin
    pos_in = hall_position_table[{hall_state, 2'b00} +: 4];
    if (reverse_direction)
      step_in = (pos_in == LAST_POSITION) ? 3'd0 : pos_in[2:0] + 3'd1;
    else
      step_in = (pos_in == 4'd0) ? 3'd5 : pos_in[2:0] - 3'd1;
    period_in = edge_time_us - revolution_start_time;
  end

  // latch item, update edge timing
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_edge_time    <= '0;
      revolution_start_time <= '0;
      pos_valid             <= 1'b0;
      step                  <= '0;
    end else if (cmd.accept) begin
      previous_edge_time <= edge_time_us;
      pos_valid          <= (pos_in <= LAST_POSITION);
      step               <= step_in;
      if ((pos_in <= LAST_POSITION) && (step_in == 3'd0))
        revolution_start_time <= edge_time_us;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      interval    <= edge_time_us - previous_edge_time;
      period      <= period_in;
      period_zero <= (period_in == 32'd0);
    end
  end

  // restoring divider: SPEED_NUMERATOR / period, one quotient bit per step
  always_comb begin
    div_trial = {div_rem, div_quot[23]};
    div_bit   = (div_trial >= {1'b0, period});
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem  <= '0;
      div_quot <= SPEED_NUMERATOR;
    end else if (cmd.div_step) begin
      div_rem  <= div_bit ? 32'(div_trial - {1'b0, period}) : div_trial[31:0];
      div_quot <= {div_quot[22:0], div_bit};
    end
  end

  // phase levels and speed of the finished item
  always_comb begin
    pattern    = drive_pattern_table[{3'b000, step} * 6'd6 +: 6];
    level_low  = duty_low & DUTY_MASK;
    level_high = duty_high & DUTY_MASK;
    if (step == 3'd0)
      speed_next = period_zero ? SPEED_NUMERATOR : div_quot;
    else
      speed_next = held_speed;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      held_speed <= '0;
    end else if (cmd.load_out) begin
      out_valid  <= 1'b1;
      held_speed <= speed_next;
    end else if (out_ready) begin
      out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      commutation_step   <= step;
      phase_a_low_level  <= pattern[0] ? level_high : 16'd0;
      phase_a_high_level <= pattern[1] ? level_low  : 16'd0;
      phase_b_low_level  <= pattern[2] ? level_high : 16'd0;
      phase_b_high_level <= pattern[3] ? level_low  : 16'd0;
      phase_c_low_level  <= pattern[4] ? level_high : 16'd0;
      phase_c_high_level <= pattern[5] ? level_low  : 16'd0;
      edge_interval_us   <= interval;
      speed_value        <= speed_next;
    end
  end

  // status to the controller
  always_comb begin
    status.pos_valid = pos_valid;
    status.step_zero = (step == 3'd0);
    status.out_free  = !out_valid || out_ready;
  end

endmodule

FILE: design/hall_six_step_commutator.sv
// ----------------------------------------------------------------------------
// hall_six_step_commutator: six-step BLDC commutation from Hall edges
// Send one item per Hall edge on in_ch (Hall state, microsecond timestamp).
// The Hall state is mapped through the position table to a commutation step;
// out_ch gives the step, six phase PWM levels, the edge interval and speed.
// An edge whose table entry is invalid updates edge timing and gives no item.
// Configuration goes through cfg_we/cfg_index/cfg_data; the user must write it
// only while the block idles, as the block itself does not enforce this.
// On step 0 the 24-step serial speed divider runs one quotient bit per cycle.
// One item is in work at a time; in_ch.ready rises again the cycle after the
// result is written, or after an edge with an invalid table entry is checked.
// The output register holds the result until out_ch takes it; a new item
// may be accepted meanwhile and waits for the register before it completes.
// Reset (rst, synchronous): all Hall table entries invalid, duties, pattern,
// direction, timing state and speed cleared, no item pending.
// ----------------------------------------------------------------------------
module hall_six_step_commutator
  import hssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  hssc_in_if.sink     in_ch,
  hssc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [35:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  hssc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  hssc_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .hall_state         (in_ch.hall_state),
    .edge_time_us       (in_ch.edge_time_us),
    .cmd                (cmd),
    .status             (status),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .commutation_step   (out_ch.commutation_step),
    .phase_a_low_level  (out_ch.phase_a_low_level),
    .phase_a_high_level (out_ch.phase_a_high_level),
    .phase_b_low_level  (out_ch.phase_b_low_level),
    .phase_b_high_level (out_ch.phase_b_high_level),
    .phase_c_low_level  (out_ch.phase_c_low_level),
    .phase_c_high_level (out_ch.phase_c_high_level),
    .edge_interval_us   (out_ch.edge_interval_us),
    .speed_value        (out_ch.speed_value)
  );

  // one item in work: no acceptance right after one
  assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while previous one in work");

  // divider only runs for a valid step-0 item
  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (status.pos_valid && status.step_zero))
    else $error("divider started without step 0");

  // a result shows up only from a load
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(cmd.load_out))
    else $error("output valid without load");

  // step stays within 0..5
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.commutation_step <= 3'd5))
    else $error("commutation step out of range");

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of hall_six_step_commutator
// Drives Hall edge items with random gaps, stalls the result channel at random,
// and checks every result against a predictor of the commutation, phase
// levels, edge interval and speed. It runs reset-state and directed edges first,
// then phases of rotation sequences and noise under changing register settings.
// ----------------------------------------------------------------------------
module tb;
  import hssc_pkg::*;

  // One commutation result, field for field as on out_ch
  typedef struct packed {
    logic [2:0]  step;
    logic [15:0] a_low;
    logic [15:0] a_high;
    logic [15:0] b_low;
    logic [15:0] b_high;
    logic [15:0] c_low;
    logic [15:0] c_high;
    logic [31:0] interval;
    logic [23:0] speed;
  } commut_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [35:0] cfg_data;

  hssc_in_if  in_ch();
  hssc_out_if out_ch();

  hall_six_step_commutator DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the registers
  logic        model_reverse;
  logic [15:0] model_duty_low;
  logic [15:0] model_duty_high;
  logic [31:0] model_hall_table;
  logic [35:0] model_pattern;

  // Predictor copy of the timing state
  logic [31:0] last_edge_time;
  logic [31:0] rev_start_time;
  logic [23:0] speed_held;

  commut_t pending_results[$];
  commut_t predicted;
  commut_t want;
  commut_t got;
  int      errors;
  bit      steady;       // no idling on either side while set
  bit      table_ok;     // hall table maps six states onto positions 0..5
  int      hall_of_pos[6];

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Run limit
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Expected result of one Hall edge; returns 0 when the edge gives no item
  function automatic bit predict_commutation(input logic [2:0] hall, input logic [31:0] now,
                                             output commut_t res);
    logic [3:0]  pos;
    logic [2:0]  step;
    logic [5:0]  pat;
    logic [31:0] period;
    logic [15:0] dl;
    logic [15:0] dh;
    res = '0;
    pos = model_hall_table[4*hall +: 4];
    res.interval = now - last_edge_time;
    last_edge_time = now;
    if (pos > LAST_POSITION) return 1'b0;
    if (model_reverse) step = (pos == LAST_POSITION) ? 3'd0 : 3'(pos + 4'd1);
    else step = (pos == 4'd0) ? 3'(LAST_POSITION) : 3'(pos - 4'd1);
    // speed is refreshed on each pass through step 0
    if (step == 3'd0) begin
      period = now - rev_start_time;
      speed_held = (period == 32'd0) ? SPEED_NUMERATOR
                                     : 24'(32'(SPEED_NUMERATOR) / period);
      rev_start_time = now;
    end
    pat = model_pattern[6*step +: 6];
    dl = model_duty_low & DUTY_MASK;
    dh = model_duty_high & DUTY_MASK;
    res.step   = step;
    res.a_low  = pat[0] ? dh : 16'd0;
    res.a_high = pat[1] ? dl : 16'd0;
    res.b_low  = pat[2] ? dh : 16'd0;
    res.b_high = pat[3] ? dl : 16'd0;
    res.c_low  = pat[4] ? dh : 16'd0;
    res.c_high = pat[5] ? dl : 16'd0;
    res.speed  = speed_held;
    return 1'b1;
  endfunction

  // Predict at each accepted input item
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      if (predict_commutation(in_ch.hall_state, in_ch.edge_time_us, predicted))
        pending_results.push_back(predicted);
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.step     = out_ch.commutation_step;
      got.a_low    = out_ch.phase_a_low_level;
      got.a_high   = out_ch.phase_a_high_level;
      got.b_low    = out_ch.phase_b_low_level;
      got.b_high   = out_ch.phase_b_high_level;
      got.c_low    = out_ch.phase_c_low_level;
      got.c_high   = out_ch.phase_c_high_level;
      got.interval = out_ch.edge_interval_us;
      got.speed    = out_ch.speed_value;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("commutation_step", want.step, got.step);
        check_field("phase_a_low_level", want.a_low, got.a_low);
        check_field("phase_a_high_level", want.a_high, got.a_high);
        check_field("phase_b_low_level", want.b_low, got.b_low);
        check_field("phase_b_high_level", want.b_high, got.b_high);
        check_field("phase_c_low_level", want.c_low, got.c_low);
        check_field("phase_c_high_level", want.c_high, got.c_high);
        check_field("edge_interval_us", want.interval, got.interval);
        check_field("speed_value", want.speed, got.speed);
      end
    end
  end

  // Result channel back-pressure
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady) begin
        out_ch.ready = 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else begin
        out_ch.ready = ~out_ch.ready;
        hold = out_ch.ready ? $urandom_range(0, 8) : pick_gap();
      end
    end
  end

  // Send one Hall edge item; called and returns at a falling edge
  task automatic send_edge(input logic [2:0] hall, input logic [31:0] stamp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.hall_state   = hall;
    in_ch.edge_time_us = stamp;
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Wait until every expected item has come and the block has settled
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Register write; block must be idle
  task automatic write_reg(input logic [2:0] idx, input logic [35:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_REVERSE_DIRECTION: model_reverse    = data[0];
      REG_DUTY_LOW:          model_duty_low   = data[15:0];
      REG_DUTY_HIGH:         model_duty_high  = data[15:0];
      REG_HALL_TABLE:        model_hall_table = data[31:0];
      REG_PATTERN_TABLE:     model_pattern    = data;
      default: ;
    endcase
  endtask

  // Reset configuration: every Hall entry invalid, so no item comes out
  task automatic test_reset_state();
    send_edge(3'd0, 32'h0000_0010);
    send_edge(3'd7, 32'hFFFF_FFF0);
    send_edge(3'd5, 32'h0000_0003);
    wait_idle();
  endtask

  // Directed edges: step wrap, speed saturation and limits, invalid entries
  task automatic test_directed();
    int k;
    wait_idle();
    // unused indexes must be ignored
    for (k = 1; k <= 3; k++) write_reg(REG_PATTERN_TABLE + 3'(k), 36'hF_FFFF_FFFF);
    write_reg(REG_HALL_TABLE, 36'h0_F654_3210);
    write_reg(REG_DUTY_LOW, 36'hF_FFFF_FFFF);
    write_reg(REG_DUTY_HIGH, 36'h0_0000_0001);
    write_reg(REG_PATTERN_TABLE, 36'hF_FFFF_FFFF);
    write_reg(REG_REVERSE_DIRECTION, 36'h0_0000_0000);
    send_edge(3'd1, 32'd0);          // step 0, zero period saturates
    send_edge(3'd1, 32'd1);          // period 1
    send_edge(3'd1, 32'd10000001);   // period of exactly ten million
    send_edge(3'd1, 32'd20000002);   // period just over, speed 0
    send_edge(3'd0, 32'hFFFF_FFFF);  // position 0 forward wraps to step 5
    send_edge(3'd1, 32'd5);          // interval wraps over 2^32
    send_edge(3'd2, 32'd6);
    send_edge(3'd3, 32'd7);
    send_edge(3'd4, 32'd8);
    send_edge(3'd5, 32'd9);
    send_edge(3'd6, 32'd100);        // invalid entries: timing only
    send_edge(3'd7, 32'd200);
    wait_idle();
    write_reg(REG_REVERSE_DIRECTION, 36'hF_FFFF_FFFF);
    write_reg(REG_DUTY_LOW, 36'h0_0000_0000);
    write_reg(REG_DUTY_HIGH, 36'hF_FFFF_FFFF);
    write_reg(REG_PATTERN_TABLE, 36'h5_5555_5555);
    send_edge(3'd5, 32'd300);        // position 5 reverse wraps to step 0
    send_edge(3'd0, 32'd400);
    send_edge(3'd4, 32'd500);
    wait_idle();
    write_reg(REG_PATTERN_TABLE, 36'hA_AAAA_AAAA);
    write_reg(REG_DUTY_LOW, 36'h0_0000_FFFF);
    send_edge(3'd2, 32'd600);
    wait_idle();
    write_reg(REG_PATTERN_TABLE, 36'h0_0000_0000);
    send_edge(3'd3, 32'd700);
    wait_idle();
  endtask

  // New register setting for one phase
  task automatic apply_phase_config(input int phase);
    int          order[8];
    int          j;
    int          k;
    int          tmp;
    logic [31:0] tbl;
    wait_idle();
    // six random Hall states onto positions 0..5, the other two invalid
    for (k = 0; k < 8; k++) order[k] = k;
    for (k = 7; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    tbl = '1;
    for (k = 0; k < 8; k++)
      tbl[4*order[k] +: 4] = (k < 6) ? 4'(k) : 4'($urandom_range(6, 15));
    for (k = 0; k < 6; k++) hall_of_pos[k] = order[k];
    table_ok = 1'b1;
    if (phase % 5 == 4) begin
      tbl = $urandom;
      table_ok = 1'b0;
    end
    write_reg(REG_HALL_TABLE, {4'($urandom), tbl});
    write_reg(REG_REVERSE_DIRECTION, {4'($urandom), 32'($urandom)});
    case (phase % 4)
      0: begin
        write_reg(REG_DUTY_LOW, {4'($urandom), 16'($urandom), 16'h0000});
        write_reg(REG_DUTY_HIGH, {4'($urandom), 16'($urandom), 16'h0000});
        write_reg(REG_PATTERN_TABLE, 36'hF_FFFF_FFFF);
      end
      1: begin
        write_reg(REG_DUTY_LOW, {4'($urandom), 16'($urandom), 16'hFFFF});
        write_reg(REG_DUTY_HIGH, {4'($urandom), 16'($urandom), 16'hFFFF});
        write_reg(REG_PATTERN_TABLE, {4'($urandom), 32'($urandom)});
      end
      default: begin
        write_reg(REG_DUTY_LOW, {4'($urandom), 32'($urandom)});
        write_reg(REG_DUTY_HIGH, {4'($urandom), 32'($urandom)});
        write_reg(REG_PATTERN_TABLE, {4'($urandom), 32'($urandom)});
      end
    endcase
  endtask

  // Rotation through the table with random timing, plus noise edges
  task automatic test_rotation(input int count);
    int          pos;
    int          dir;
    int          r;
    logic [2:0]  hall;
    logic [31:0] stamp;
    pos   = $urandom_range(0, 5);
    dir   = $urandom_range(0, 1) ? 1 : 5;
    stamp = $urandom;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 3) stamp = $urandom;
      else if (r < 6) stamp = stamp;
      else if (r < 10) stamp += $urandom_range(0, 4000000);
      else stamp += $urandom_range(1, 5000);
      r = $urandom_range(0, 99);
      if (table_ok && r < 85) begin
        if ($urandom_range(0, 19) == 0) pos = $urandom_range(0, 5);
        else pos = (pos + dir) % 6;
        hall = 3'(hall_of_pos[pos]);
      end else begin
        hall = 3'($urandom_range(0, 7));
      end
      send_edge(hall, stamp);
    end
  endtask

  // Main sequence
  initial begin
    int phase;
    errors           = 0;
    steady           = 1'b0;
    table_ok         = 1'b0;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.hall_state = '0;
    in_ch.edge_time_us = '0;
    model_reverse    = 1'b0;
    model_duty_low   = '0;
    model_duty_high  = '0;
    model_hall_table = HALL_TABLE_RESET;
    model_pattern    = '0;
    last_edge_time   = '0;
    rev_start_time   = '0;
    speed_held       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_directed();
    for (phase = 0; phase < 10; phase++) begin
      apply_phase_config(phase);
      steady = (phase == 3 || phase == 7);
      test_rotation(148);
    end
    steady = 1'b0;

    wait_idle();
    if (pending_results.size() != 0) begin
      $display("%0t: expected %0d more results, actual none", $time,
               pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
